FILE: hdl/sdri_pkg.sv
`timescale 1ns / 1ps

package sdri_pkg;

   localparam int MAP_BITS  = 6;
   localparam int FRAC_BITS = 16;

   localparam int POS_W  = MAP_BITS + FRAC_BITS;
   localparam int DIR_W  = FRAC_BITS + 2;
   localparam int OPEN_W = FRAC_BITS + 1;
   localparam int DIST_W = 8 + FRAC_BITS;

   localparam int D_W   = DIR_W;
   localparam int R_W   = D_W;
   localparam int N_W   = POS_W + FRAC_BITS;
   localparam int T_W   = N_W;
   localparam int LO_W  = (T_W + 1) / 2;
   localparam int HI_W  = T_W - LO_W;
   localparam int P_W   = T_W + D_W;
   localparam int OFF_W = POS_W + 3;
   localparam int C_W   = POS_W + 4;

   localparam int PAR_LIM = ((1 << FRAC_BITS) + 999999) / 1000000;
   localparam int T_MIN   = (1 << FRAC_BITS) / 10000;

   localparam logic [OFF_W-1:0]  OFF_CAP  = OFF_W'(1) << (POS_W + 2);
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic [MAP_BITS-1:0]     door_col;
      logic [MAP_BITS-1:0]     door_row;
      logic                    door_vertical;
      logic [OPEN_W-1:0]       door_open;
      logic [POS_W-1:0]        player_x;
      logic [POS_W-1:0]        player_y;
      logic signed [DIR_W-1:0] ray_dx;
      logic signed [DIR_W-1:0] ray_dy;
   } sdri_req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
      logic              side;
   } sdri_rsp_type;

   typedef struct packed {
      logic                miss;
      logic                vert;
      logic                neg_b;
      logic [POS_W-1:0]    pos_b;
      logic [MAP_BITS-1:0] cell_b;
      logic [OPEN_W-1:0]   open;
      logic [D_W-1:0]      db;
   } sdri_side_type;

   typedef struct packed {
      sdri_side_type  side;
      logic [D_W-1:0] da;
      logic [R_W-1:0] rem;
      logic [N_W-1:0] num;
      logic [T_W-1:0] quo;
   } sdri_div_type;

endpackage

FILE: hdl/sdri_req_if.sv
`timescale 1ns / 1ps

interface sdri_req_if;
   import sdri_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MAP_BITS-1:0]     door_col;
   logic [MAP_BITS-1:0]     door_row;
   logic                    door_vertical;
   logic [OPEN_W-1:0]       door_open;
   logic [POS_W-1:0]        player_x;
   logic [POS_W-1:0]        player_y;
   logic signed [DIR_W-1:0] ray_dx;
   logic signed [DIR_W-1:0] ray_dy;

   modport source (
      output valid, door_col, door_row, door_vertical, door_open,
             player_x, player_y, ray_dx, ray_dy,
      input  ready
   );

   modport sink (
      input  valid, door_col, door_row, door_vertical, door_open,
             player_x, player_y, ray_dx, ray_dy,
      output ready
   );
endinterface

FILE: hdl/sdri_rsp_if.sv
`timescale 1ns / 1ps

interface sdri_rsp_if;
   import sdri_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [DIST_W-1:0] distance;
   logic              side;

   modport source (
      output valid, hit, distance, side,
      input  ready
   );

   modport sink (
      input  valid, hit, distance, side,
      output ready
   );
endinterface

FILE: hdl/sliding_door_ray_intersect_top.sv
`timescale 1ns / 1ps

// Pipeline: an input stage, one divider cell per quotient bit, and multiply, test and output
// stages lie between accept and result valid.
// Throughput: one item per cycle; the pipeline stalls only when its last stage and the
// output register are both full and the result is not taken.
// Reset: synchronous, clears all stage valid bits; no result is pending after reset.
module sliding_door_ray_intersect_top (
   input  logic      clock,
   input  logic      reset,
   sdri_req_if.sink   req_ch,
   sdri_rsp_if.source rsp_ch
);
   import sdri_pkg::*;

   sdri_req_type  req_data;
   logic          pipe_en;
   logic          prep_valid;
   sdri_div_type  prep_data;
   logic          chain_valid [T_W+1];
   sdri_div_type  chain_data  [T_W+1];
   logic          last_valid;
   sdri_rsp_type  last_rsp;
   logic          rsp_valid_ff;
   sdri_rsp_type  rsp_ff;
   logic          rsp_load;

   always_comb begin
      req_data.door_col      = req_ch.door_col;
      req_data.door_row      = req_ch.door_row;
      req_data.door_vertical = req_ch.door_vertical;
      req_data.door_open     = req_ch.door_open;
      req_data.player_x      = req_ch.player_x;
      req_data.player_y      = req_ch.player_y;
      req_data.ray_dx        = req_ch.ray_dx;
      req_data.ray_dy        = req_ch.ray_dy;
   end

   assign rsp_load     = !rsp_valid_ff || rsp_ch.ready;
   assign pipe_en      = !last_valid || rsp_load;
   assign req_ch.ready = pipe_en;

   sdri_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .src_valid (req_ch.valid),
      .src_data  (req_data),
      .dst_valid (prep_valid),
      .dst_data  (prep_data)
   );

   assign chain_valid[0] = prep_valid;
   assign chain_data[0]  = prep_data;

   genvar g;
   for (g = 0; g < T_W; g++) begin : g_cell
      sdri_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .src_valid (chain_valid[g]),
         .src_data  (chain_data[g]),
         .dst_valid (chain_valid[g+1]),
         .dst_data  (chain_data[g+1])
      );
   end

   sdri_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .src_valid (chain_valid[T_W]),
      .src_data  (chain_data[T_W]),
      .dst_valid (last_valid),
      .dst_rsp   (last_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= last_rsp;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.hit      = rsp_ff.hit;
   assign rsp_ch.distance = rsp_ff.distance;
   assign rsp_ch.side     = rsp_ff.side;

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.hit |-> (rsp_ff.distance == '0) && !rsp_ff.side)
      else $error("miss item carries distance or side");

   a_hit_beyond_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> rsp_ff.distance > DIST_W'(T_MIN))
      else $error("hit item at or below minimum distance");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> last_valid && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled with room in pipeline");
endmodule

FILE: hdl/sdri_prep.sv
`timescale 1ns / 1ps

module sdri_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  src_valid,
   input  sdri_pkg::sdri_req_type src_data,
   output logic                  dst_valid,
   output sdri_pkg::sdri_div_type dst_data
);
   import sdri_pkg::*;

   logic                  valid_ff;
   sdri_div_type          data_ff;
   sdri_div_type          data_in;

   logic [MAP_BITS-1:0]   cell_a;
   logic [MAP_BITS-1:0]   cell_b;
   logic [POS_W-1:0]      pos_a;
   logic [POS_W-1:0]      pos_b;
   logic [DIR_W-1:0]      dir_a;
   logic [DIR_W-1:0]      dir_b;
   logic                  neg_a;
   logic                  neg_b;
   logic [D_W-1:0]        da;
   logic [D_W-1:0]        db;
   logic [POS_W-1:0]      plane;
   logic [POS_W:0]        num;
   logic                  num_neg;
   logic [POS_W-1:0]      num_mag;

   always_comb begin
      cell_a  = src_data.door_vertical ? src_data.door_col : src_data.door_row;
      cell_b  = src_data.door_vertical ? src_data.door_row : src_data.door_col;
      pos_a   = src_data.door_vertical ? src_data.player_x : src_data.player_y;
      pos_b   = src_data.door_vertical ? src_data.player_y : src_data.player_x;
      dir_a   = src_data.door_vertical ? src_data.ray_dx : src_data.ray_dy;
      dir_b   = src_data.door_vertical ? src_data.ray_dy : src_data.ray_dx;
      neg_a   = dir_a[DIR_W-1];
      neg_b   = dir_b[DIR_W-1];
      da      = neg_a ? (~dir_a + DIR_W'(1)) : dir_a;
      db      = neg_b ? (~dir_b + DIR_W'(1)) : dir_b;
      plane   = {cell_a, 1'b1, {(FRAC_BITS-1){1'b0}}};
      num     = {1'b0, plane} - {1'b0, pos_a};
      num_neg = num[POS_W];
      num_mag = num_neg ? POS_W'(~num + (POS_W+1)'(1)) : num[POS_W-1:0];

      data_in.side.miss  = (da < D_W'(PAR_LIM)) || (num == '0) || (num_neg != neg_a);
      data_in.side.vert  = src_data.door_vertical;
      data_in.side.neg_b = neg_b;
      data_in.side.pos_b = pos_b;
      data_in.side.cell_b = cell_b;
      data_in.side.open  = src_data.door_open;
      data_in.side.db    = db;
      data_in.da         = da;
      data_in.rem        = '0;
      data_in.num        = {num_mag, {FRAC_BITS{1'b0}}};
      data_in.quo        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;
endmodule

FILE: hdl/sdri_div_cell.sv
`timescale 1ns / 1ps

module sdri_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  src_valid,
   input  sdri_pkg::sdri_div_type src_data,
   output logic                  dst_valid,
   output sdri_pkg::sdri_div_type dst_data
);
   import sdri_pkg::*;

   logic           valid_ff;
   sdri_div_type   data_ff;
   sdri_div_type   data_in;
   logic [R_W:0]   trial;
   logic           ge;

   always_comb begin
      trial        = {src_data.rem, src_data.num[N_W-1]};
      ge           = trial >= {1'b0, src_data.da};
      data_in      = src_data;
      data_in.num  = {src_data.num[N_W-2:0], 1'b0};
      data_in.quo  = {src_data.quo[T_W-2:0], ge};
      data_in.rem  = ge ? R_W'(trial - {1'b0, src_data.da}) : R_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.side.miss |-> data_ff.rem < data_ff.da)
      else $error("remainder not below divisor");
endmodule

FILE: hdl/sdri_post.sv
`timescale 1ns / 1ps

module sdri_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  src_valid,
   input  sdri_pkg::sdri_div_type src_data,
   output logic                  dst_valid,
   output sdri_pkg::sdri_rsp_type dst_rsp
);
   import sdri_pkg::*;

   typedef struct packed {
      sdri_side_type          side;
      logic [T_W-1:0]         t;
      logic [HI_W+D_W-1:0]    p_hi;
      logic [LO_W+D_W-1:0]    p_lo;
   } mul_type;

   typedef struct packed {
      logic                miss;
      logic                vert;
      logic                neg_b;
      logic [POS_W-1:0]    pos_b;
      logic [MAP_BITS-1:0] cell_b;
      logic [OPEN_W-1:0]   open;
      logic [OFF_W-1:0]    off;
      logic [DIST_W-1:0]   dist_sat;
   } fin_type;

   logic                   m1_valid_ff;
   mul_type                m1_ff;
   mul_type                m1_in;
   logic                   m2_valid_ff;
   fin_type                m2_ff;
   fin_type                m2_in;

   logic [P_W-1:0]         sum;
   logic [P_W-FRAC_BITS-1:0] off_full;
   logic signed [C_W-1:0]  coord;
   logic signed [C_W-1:0]  lo_b;
   logic signed [C_W-1:0]  hi_b;
   logic [MAP_BITS:0]      cell_next;
   logic                   hit;

   always_comb begin
      m1_in.side = src_data.side;
      m1_in.t    = src_data.quo;
      m1_in.p_hi = {{D_W{1'b0}}, src_data.quo[T_W-1:LO_W]} *
                   {{HI_W{1'b0}}, src_data.side.db};
      m1_in.p_lo = {{D_W{1'b0}}, src_data.quo[LO_W-1:0]} *
                   {{LO_W{1'b0}}, src_data.side.db};
   end

   always_comb begin
      sum      = {m1_ff.p_hi, {LO_W{1'b0}}} + P_W'(m1_ff.p_lo);
      off_full = sum[P_W-1:FRAC_BITS];
      m2_in.miss   = m1_ff.side.miss || (m1_ff.t <= T_W'(T_MIN));
      m2_in.vert   = m1_ff.side.vert;
      m2_in.neg_b  = m1_ff.side.neg_b;
      m2_in.pos_b  = m1_ff.side.pos_b;
      m2_in.cell_b = m1_ff.side.cell_b;
      m2_in.open   = m1_ff.side.open;
      m2_in.off    = (off_full > (P_W-FRAC_BITS)'(OFF_CAP)) ? OFF_CAP : OFF_W'(off_full);
      m2_in.dist_sat = (m1_ff.t > T_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(m1_ff.t);
   end

   always_comb begin
      coord     = m2_ff.neg_b ? (C_W'(m2_ff.pos_b) - C_W'(m2_ff.off))
                              : (C_W'(m2_ff.pos_b) + C_W'(m2_ff.off));
      lo_b      = C_W'({m2_ff.cell_b, {FRAC_BITS{1'b0}}}) + C_W'(m2_ff.open);
      cell_next = {1'b0, m2_ff.cell_b} + (MAP_BITS+1)'(1);
      hi_b      = C_W'({cell_next, {FRAC_BITS{1'b0}}});
      hit       = !m2_ff.miss && (coord >= lo_b) && (coord <= hi_b);
      dst_rsp.hit      = hit;
      dst_rsp.distance = hit ? m2_ff.dist_sat : '0;
      dst_rsp.side     = hit && !m2_ff.vert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= src_valid;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   assign dst_valid = m2_valid_ff;
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sdri_pkg::*;

   localparam longint UNIT         = 64'sd1 << FRAC_BITS;
   localparam longint HALF         = UNIT / 2;
   localparam longint POS_TOP      = (64'sd1 << POS_W) - 1;
   localparam longint DIR_TOP      = (64'sd1 << (DIR_W - 1)) - 1;
   localparam longint OPEN_TOP     = (64'sd1 << OPEN_W) - 1;
   localparam longint DIST_TOP     = (64'sd1 << DIST_W) - 1;
   localparam longint OFFSET_LIMIT = 64'sd1 << (POS_W + 2);

   localparam int MODE_STEADY     = 0;
   localparam int MODE_SEND_IDLE  = 1;
   localparam int MODE_RECV_STALL = 2;
   localparam int MODE_BOTH_IDLE  = 3;

   localparam int ITEMS_PER_MODE = 104;
   localparam int BURST_ITEMS    = 60;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct {
      sdri_req_type req;
      bit           typed;
      sdri_rsp_type rsp;
   } door_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdri_req_if req_ch ();
   sdri_rsp_if rsp_ch ();

   sliding_door_ray_intersect_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sdri_rsp_type  door_results_due[$];
   door_case_type door_cases[$];
   int            traffic_mode = MODE_STEADY;
   int            hold_left    = 0;
   int            mismatches   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit door_axis_hit(input longint cell_a, input longint pos_a,
                                        input longint dir_a, input longint cell_b,
                                        input longint pos_b, input longint dir_b,
                                        input longint open, output longint t);
      longint da, db, plane, num, hi, lo, off, coord, lo_b, hi_b;
      t = 0;
      da = (dir_a < 0) ? -dir_a : dir_a;
      db = (dir_b < 0) ? -dir_b : dir_b;
      if (da * 1000000 < UNIT) return 1'b0;
      plane = (cell_a << FRAC_BITS) + HALF;
      num = plane - pos_a;
      if (num == 0 || ((num < 0) != (dir_a < 0))) return 1'b0;
      t = (((num < 0) ? -num : num) << FRAC_BITS) / da;
      if (t < UNIT && t * 10000 <= UNIT) return 1'b0;
      hi = t >> FRAC_BITS;
      lo = t & (UNIT - 1);
      if (hi != 0 && db > OFFSET_LIMIT / hi) begin
         off = OFFSET_LIMIT;
      end else begin
         off = hi * db + ((lo * db) >> FRAC_BITS);
         if (off > OFFSET_LIMIT) off = OFFSET_LIMIT;
      end
      coord = pos_b + ((dir_b < 0) ? -off : off);
      lo_b = (cell_b << FRAC_BITS) + open;
      hi_b = (cell_b + 1) << FRAC_BITS;
      return (coord >= lo_b) && (coord <= hi_b);
   endfunction

   function automatic sdri_rsp_type predict_door_test(input sdri_req_type r);
      sdri_rsp_type o;
      longint       t;
      bit           hit;
      if (r.door_vertical) begin
         hit = door_axis_hit(longint'(r.door_col), longint'(r.player_x),
                             longint'($signed(r.ray_dx)), longint'(r.door_row),
                             longint'(r.player_y), longint'($signed(r.ray_dy)),
                             longint'(r.door_open), t);
      end else begin
         hit = door_axis_hit(longint'(r.door_row), longint'(r.player_y),
                             longint'($signed(r.ray_dy)), longint'(r.door_col),
                             longint'(r.player_x), longint'($signed(r.ray_dx)),
                             longint'(r.door_open), t);
      end
      o.hit = hit;
      o.distance = hit ? DIST_W'((t > DIST_TOP) ? DIST_TOP : t) : '0;
      o.side = hit && !r.door_vertical;
      return o;
   endfunction

   function automatic void add_case(input longint col, input longint row, input longint vert,
                                    input longint open, input longint px, input longint py,
                                    input longint dx, input longint dy, input bit typed,
                                    input longint hit, input longint distance,
                                    input longint side);
      door_case_type c;
      c.req.door_col = MAP_BITS'(col);
      c.req.door_row = MAP_BITS'(row);
      c.req.door_vertical = vert[0];
      c.req.door_open = OPEN_W'(open);
      c.req.player_x = POS_W'(px);
      c.req.player_y = POS_W'(py);
      c.req.ray_dx = DIR_W'(dx);
      c.req.ray_dy = DIR_W'(dy);
      c.typed = typed;
      c.rsp.hit = hit[0];
      c.rsp.distance = DIST_W'(distance);
      c.rsp.side = side[0];
      door_cases.insert(door_cases.size(), c);
   endfunction

   function automatic sdri_req_type aimed_door_ray();
      sdri_req_type r;
      longint       cell_a, cell_b, plane, pa, pb, tb, va, vb, ma, mb, dir_a, dir_b;
      int           sh;
      r.door_vertical = 1'($urandom_range(0, 1));
      r.door_col = MAP_BITS'($urandom);
      r.door_row = MAP_BITS'($urandom);
      case ($urandom_range(0, 9))
         0: r.door_open = '0;
         1: r.door_open = OPEN_W'(UNIT);
         2: r.door_open = OPEN_W'($urandom_range(UNIT + 1, OPEN_TOP));
         default: r.door_open = OPEN_W'($urandom_range(0, UNIT));
      endcase
      cell_a = r.door_vertical ? longint'(r.door_col) : longint'(r.door_row);
      cell_b = r.door_vertical ? longint'(r.door_row) : longint'(r.door_col);
      plane = cell_a * UNIT + HALF;
      if ($urandom_range(0, 15) == 0) begin
         pa = plane + longint'($urandom_range(0, 16)) - 8;
      end else begin
         pa = plane + longint'($urandom_range(0, 16 * UNIT)) - 8 * UNIT;
      end
      pb = cell_b * UNIT + longint'($urandom_range(0, 17 * UNIT)) - 8 * UNIT;
      if (pa < 0) pa = 0;
      if (pa > POS_TOP) pa = POS_TOP;
      if (pb < 0) pb = 0;
      if (pb > POS_TOP) pb = POS_TOP;
      tb = cell_b * UNIT + longint'($urandom_range(0, 3 * HALF)) - UNIT / 4;
      va = plane - pa;
      vb = tb - pb;
      ma = (va < 0) ? -va : va;
      mb = (vb < 0) ? -vb : vb;
      sh = 0;
      while ((ma >> sh) > DIR_TOP || (mb >> sh) > DIR_TOP) sh++;
      sh += ($urandom_range(0, 7) == 0) ? $urandom_range(4, 18) : $urandom_range(0, 3);
      dir_a = (va < 0) ? -(ma >> sh) : (ma >> sh);
      dir_b = (vb < 0) ? -(mb >> sh) : (mb >> sh);
      r.player_x = POS_W'(r.door_vertical ? pa : pb);
      r.player_y = POS_W'(r.door_vertical ? pb : pa);
      r.ray_dx = DIR_W'(r.door_vertical ? dir_a : dir_b);
      r.ray_dy = DIR_W'(r.door_vertical ? dir_b : dir_a);
      return r;
   endfunction

   function automatic sdri_req_type noise_door_ray();
      sdri_req_type r;
      r.door_col = MAP_BITS'($urandom);
      r.door_row = MAP_BITS'($urandom);
      r.door_vertical = 1'($urandom_range(0, 1));
      r.door_open = OPEN_W'($urandom);
      r.player_x = POS_W'($urandom);
      r.player_y = POS_W'($urandom);
      r.ray_dx = DIR_W'($urandom);
      r.ray_dy = DIR_W'($urandom);
      return r;
   endfunction

   task automatic offer_item(input sdri_req_type it, input sdri_rsp_type due);
      int pct;
      pct = (traffic_mode == MODE_SEND_IDLE) ? 78 : (traffic_mode == MODE_BOTH_IDLE) ? 8 : 0;
      while ($urandom_range(0, 99) < pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.door_col = it.door_col;
      req_ch.door_row = it.door_row;
      req_ch.door_vertical = it.door_vertical;
      req_ch.door_open = it.door_open;
      req_ch.player_x = it.player_x;
      req_ch.player_y = it.player_y;
      req_ch.ray_dx = it.ray_dx;
      req_ch.ray_dy = it.ray_dy;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      door_results_due.insert(door_results_due.size(), due);
   endtask

   task automatic settle_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (door_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      sdri_req_type r;
      for (int i = 0; i < count; i++) begin
         r = ($urandom_range(0, 9) < 7) ? aimed_door_ray() : noise_door_ray();
         offer_item(r, predict_door_test(r));
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            case (traffic_mode)
               MODE_RECV_STALL: rsp_ch.ready = ($urandom_range(0, 99) >= 78);
               MODE_BOTH_IDLE:  rsp_ch.ready = ($urandom_range(0, 99) >= 8);
               default:         rsp_ch.ready = 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      sdri_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (door_results_due.size() == 0) begin
            $error("unexpected item: hit %0d distance %0d side %0d",
                   rsp_ch.hit, rsp_ch.distance, rsp_ch.side);
            mismatches++;
         end else begin
            want = door_results_due.pop_front();
            if (rsp_ch.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_ch.hit);
               mismatches++;
            end
            if (rsp_ch.distance !== want.distance) begin
               $error("distance: expected %0d, actual %0d", want.distance, rsp_ch.distance);
               mismatches++;
            end
            if (rsp_ch.side !== want.side) begin
               $error("side: expected %0d, actual %0d", want.side, rsp_ch.side);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      door_case_type c;
      req_ch.valid = 1'b0;
      req_ch.door_col = '0;
      req_ch.door_row = '0;
      req_ch.door_vertical = 1'b0;
      req_ch.door_open = '0;
      req_ch.player_x = '0;
      req_ch.player_y = '0;
      req_ch.ray_dx = '0;
      req_ch.ray_dy = '0;

      add_case(2, 2, 1, 0, 3 * HALF, 5 * HALF, UNIT, 0, 1, 1, UNIT, 0);
      add_case(3, 3, 0, 0, 7 * HALF, 3 * HALF, 0, UNIT, 1, 1, 2 * UNIT, 1);
      add_case(2, 2, 1, 0, 3 * HALF, 5 * HALF, 0, UNIT, 1, 0, 0, 0);
      add_case(3, 3, 0, 0, 7 * HALF, 3 * HALF, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 7 * HALF, 5 * HALF, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 5 * HALF, 5 * HALF, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 5 * HALF - 1, 5 * HALF, DIR_TOP, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 5 * HALF - 6, 5 * HALF, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 5 * HALF - 7, 5 * HALF, UNIT, 0, 1, 1, 7, 0);
      add_case(2, 2, 1, 0, 5 * HALF - 2, 5 * HALF, 16384, 0, 0, 0, 0, 0);
      add_case(2, 2, 1, 0, 5 * HALF - 1, 5 * HALF, 10, 0, 0, 0, 0, 0);
      add_case(5, 5, 1, 0, 9 * HALF, 11 * HALF, 1, 0, 1, 1, DIST_TOP, 0);
      add_case(2, 2, 1, UNIT, 3 * HALF, 3 * UNIT, UNIT, 0, 1, 1, UNIT, 0);
      add_case(2, 2, 1, UNIT + 1, 3 * HALF, 3 * UNIT, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, OPEN_TOP, 3 * HALF, 5 * HALF, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 3 * HALF, 2 * UNIT, UNIT, 0, 1, 1, UNIT, 0);
      add_case(2, 2, 1, 0, 3 * HALF, 2 * UNIT - 1, UNIT, 0, 1, 0, 0, 0);
      add_case(2, 2, 1, 0, 3 * HALF, 3 * UNIT + 1, UNIT, 0, 1, 0, 0, 0);
      add_case(7, 4, 0, 0, 7 * UNIT + HALF, 6 * UNIT, 0, -UNIT, 1, 1, 3 * HALF, 1);
      add_case(63, 63, 1, 0, POS_TOP, 0, -(DIR_TOP + 1), DIR_TOP, 0, 0, 0, 0);
      add_case(0, 63, 1, UNIT - 1, 0, POS_TOP, DIR_TOP, -(DIR_TOP + 1), 0, 0, 0, 0);
      add_case(63, 0, 0, HALF, POS_TOP, 0, -(DIR_TOP + 1), DIR_TOP, 0, 0, 0, 0);
      add_case(63, 0, 1, 0, 0, 0, 1, DIR_TOP, 0, 0, 0, 0);
      add_case(10, 10, 0, 30000, 10 * UNIT + 45000, 8 * UNIT, 8192, 32768, 0, 0, 0, 0);
      add_case(0, 0, 1, 0, 0, 0, DIR_TOP, DIR_TOP, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      foreach (door_cases[i]) begin
         c = door_cases[i];
         offer_item(c.req, c.typed ? c.rsp : predict_door_test(c.req));
      end
      settle_results();

      for (int m = MODE_STEADY; m <= MODE_BOTH_IDLE; m++) begin
         traffic_mode = m;
         run_random(ITEMS_PER_MODE);
         settle_results();
      end

      traffic_mode = MODE_STEADY;
      hold_left = HOLD_CYCLES;
      run_random(BURST_ITEMS);
      settle_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && door_results_due.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
